[hw/rtl/jii_pkg.sv]
// Shared types, register map and helper functions for the Julia-set point pipeline.
package jii_pkg;

   // Width of the digit word carried with each point.
   localparam int WORD_BITS = 30;

   // Register map, indexed by paddr[3:2].
   localparam logic [1:0] REG_C_RE  = 2'd0;
   localparam logic [1:0] REG_C_IM  = 2'd1;
   localparam logic [1:0] REG_ORDER = 2'd2;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

   // Point passed from one cell to the next.
   typedef struct packed {
      logic                 valid;
      logic [WORD_BITS-1:0] word;
      logic signed [31:0]   re;
      logic signed [31:0]   im;
   } point_type;

   // Sideband carried along the stages inside one cell.
   typedef struct packed {
      logic                 valid;
      logic [WORD_BITS-1:0] word;
      logic                 one;
      logic                 a_neg;
      logic                 b_neg;
      logic [31:0]          ua;
      logic [31:0]          ub;
   } side_type;

   // Saturate a 33-bit signed difference to 32 bits.
   function automatic logic [31:0] sat32(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'h8000_0000 : POS_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Magnitude of a 32-bit signed value; the most negative value maps to 2^31.
   function automatic logic [31:0] abs32(input logic [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

endpackage

[hw/rtl/jii_sqrt_stage.sv]
// One pipelined step of the bit-pair integer square root.
module jii_sqrt_stage import jii_pkg::*; #(
   parameter int BIT_POS = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [63:0] rad_prev,
   input  logic [63:0] root_prev,
   input  side_type    side_prev,
   output logic [63:0] rad,
   output logic [63:0] root,
   output side_type    side
);

   localparam logic [63:0] ONE_BIT = 64'd1 << BIT_POS;

   logic [63:0] trial;
   logic [63:0] rad_in, rad_ff;
   logic [63:0] root_in, root_ff;
   side_type    side_ff;

   // Try to place the current bit pair; keep the partial root either way.
   always_comb begin
      trial = root_prev + ONE_BIT;
      if (rad_prev >= trial) begin
         rad_in  = rad_prev - trial;
         root_in = (root_prev >> 1) + ONE_BIT;
      end else begin
         rad_in  = rad_prev;
         root_in = root_prev >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff <= side_prev;
         rad_ff  <= rad_in;
         root_ff <= root_in;
      end
   end

   assign rad  = rad_ff;
   assign root = root_ff;
   assign side = side_ff;

endmodule

[hw/rtl/jii_div_stage.sv]
// One pipelined step of a restoring divider, one quotient bit per stage.
module jii_div_stage import jii_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [63:0] num_prev,
   input  logic [31:0] rem_prev,
   input  logic [63:0] quot_prev,
   input  logic [31:0] div_prev,
   input  side_type    side_prev,
   output logic [63:0] num,
   output logic [31:0] rem,
   output logic [63:0] quot,
   output logic [31:0] div,
   output side_type    side
);

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;
   logic [63:0] num_in, num_ff;
   logic [31:0] rem_in, rem_ff;
   logic [63:0] quot_in, quot_ff;
   logic [31:0] div_ff;
   side_type    side_ff;

   // Bring down the next dividend bit and subtract the divisor if it fits.
   always_comb begin
      trial   = {rem_prev, num_prev[63]};
      diff    = trial - {1'b0, div_prev};
      fits    = trial >= {1'b0, div_prev};
      rem_in  = fits ? diff[31:0] : trial[31:0];
      quot_in = {quot_prev[62:0], fits};
      num_in  = {num_prev[62:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff <= side_prev;
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         div_ff  <= div_prev;
      end
   end

   assign num  = num_ff;
   assign rem  = rem_ff;
   assign quot = quot_ff;
   assign div  = div_ff;
   assign side = side_ff;

endmodule

[hw/rtl/jii_cell.sv]
// One inverse step z <- +-sqrt(z - c) as a fully pipelined cell of the chain.
module jii_cell import jii_pkg::*; #(
   parameter int FRAC_BITS = 28,
   parameter int POS_LSB   = 0,
   parameter int POS_MSB   = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [31:0] c_re,
   input  logic [31:0] c_im,
   input  logic        order,
   input  point_type   pt_prev,
   output point_type   pt
);

   localparam int SHIFT   = FRAC_BITS - 1;
   localparam int LSB_IDX = (POS_LSB < WORD_BITS) ? POS_LSB : 0;
   localparam int MSB_IDX = (POS_MSB < WORD_BITS) ? POS_MSB : 0;

   logic        bit_lsb, bit_msb;
   logic [32:0] d_re, d_im;
   logic [31:0] w_re, w_im;
   side_type    side1_in, side1_ff, side2_ff, side3_ff, side4_ff;
   logic [63:0] sqa_ff, sqb_ff, rad3_ff, rad4_ff;
   logic [32:0] m_sum;

   logic [63:0] rad_a  [0:32];
   logic [63:0] root_a [0:32];
   side_type    side_a [0:32];
   logic [63:0] rad_b  [0:32];
   logic [63:0] root_b [0:32];
   side_type    side_b [0:32];
   logic [63:0] num_d  [0:64];
   logic [31:0] rem_d  [0:64];
   logic [63:0] quot_d [0:64];
   logic [31:0] div_d  [0:64];
   side_type    side_d [0:64];

   logic [31:0] p_val, q_val, sp, sq;
   logic [31:0] re_root, im_root;
   point_type   pt_in, pt_ff;

   // Digit for this cell; digits past the word are zero.
   assign bit_lsb = (POS_LSB < WORD_BITS) && pt_prev.word[LSB_IDX];
   assign bit_msb = (POS_MSB < WORD_BITS) && pt_prev.word[MSB_IDX];

   // Saturated difference w = z - c and its magnitudes.
   always_comb begin
      d_re           = {pt_prev.re[31], pt_prev.re} - {c_re[31], c_re};
      d_im           = {pt_prev.im[31], pt_prev.im} - {c_im[31], c_im};
      w_re           = sat32(d_re);
      w_im           = sat32(d_im);
      side1_in.valid = pt_prev.valid;
      side1_in.word  = pt_prev.word;
      side1_in.one   = order ? bit_msb : bit_lsb;
      side1_in.a_neg = w_re[31];
      side1_in.b_neg = w_im[31];
      side1_in.ua    = abs32(w_re);
      side1_in.ub    = abs32(w_im);
   end

   // Front stages: difference, squares, sum of squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
         side3_ff.valid <= 1'b0;
      end else if (en) begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         sqa_ff   <= 64'(side1_ff.ua) * 64'(side1_ff.ua);
         sqb_ff   <= 64'(side1_ff.ub) * 64'(side1_ff.ub);
         side3_ff <= side2_ff;
         rad3_ff  <= sqa_ff + sqb_ff;
      end
   end

   // Modulus M = floor(sqrt(A^2 + B^2)).
   assign rad_a[0]  = rad3_ff;
   assign root_a[0] = 64'd0;
   assign side_a[0] = side3_ff;

   for (genvar k = 0; k < 32; k++) begin : g_sqrt_m
      jii_sqrt_stage #(.BIT_POS(62 - 2 * k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .rad_prev  (rad_a[k]),
         .root_prev (root_a[k]),
         .side_prev (side_a[k]),
         .rad       (rad_a[k+1]),
         .root      (root_a[k+1]),
         .side      (side_a[k+1])
      );
   end

   // Radicand for P: (M + |A|) scaled, wrapping at 64 bits.
   assign m_sum = {1'b0, root_a[32][31:0]} + {1'b0, side_a[32].ua};

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff.valid <= 1'b0;
      end else if (en) begin
         side4_ff <= side_a[32];
         rad4_ff  <= 64'(m_sum) << SHIFT;
      end
   end

   // P = floor(sqrt((M + |A|) * 2^(FRAC_BITS-1))).
   assign rad_b[0]  = rad4_ff;
   assign root_b[0] = 64'd0;
   assign side_b[0] = side4_ff;

   for (genvar k = 0; k < 32; k++) begin : g_sqrt_p
      jii_sqrt_stage #(.BIT_POS(62 - 2 * k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .rad_prev  (rad_b[k]),
         .root_prev (root_b[k]),
         .side_prev (side_b[k]),
         .rad       (rad_b[k+1]),
         .root      (root_b[k+1]),
         .side      (side_b[k+1])
      );
   end

   // Q = floor(|B| * 2^(FRAC_BITS-1) / P).
   assign num_d[0]  = 64'(side_b[32].ub) << SHIFT;
   assign rem_d[0]  = 32'd0;
   assign quot_d[0] = 64'd0;
   assign div_d[0]  = root_b[32][31:0];
   assign side_d[0] = side_b[32];

   for (genvar k = 0; k < 64; k++) begin : g_div
      jii_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .num_prev  (num_d[k]),
         .rem_prev  (rem_d[k]),
         .quot_prev (quot_d[k]),
         .div_prev  (div_d[k]),
         .side_prev (side_d[k]),
         .num       (num_d[k+1]),
         .rem       (rem_d[k+1]),
         .quot      (quot_d[k+1]),
         .div       (div_d[k+1]),
         .side      (side_d[k+1])
      );
   end

   // Assemble the principal root, then apply the branch digit.
   always_comb begin
      p_val = div_d[64];
      sp    = p_val[31] ? POS_MAX : p_val;
      if (p_val == 32'd0) begin
         sq = 32'd0;
      end else begin
         sq = (quot_d[64][63:31] != 33'd0) ? POS_MAX : quot_d[64][31:0];
      end
      q_val = sq;
      if (!side_d[64].a_neg) begin
         re_root = sp;
         im_root = side_d[64].b_neg ? (~q_val + 32'd1) : q_val;
      end else begin
         re_root = q_val;
         im_root = side_d[64].b_neg ? (~sp + 32'd1) : sp;
      end
      pt_in.valid = side_d[64].valid;
      pt_in.word  = side_d[64].word;
      pt_in.re    = side_d[64].one ? (~re_root + 32'd1) : re_root;
      pt_in.im    = side_d[64].one ? (~im_root + 32'd1) : im_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff.valid <= 1'b0;
      end else if (en) begin
         pt_ff <= pt_in;
      end
   end

   assign pt = pt_ff;

endmodule

[hw/rtl/julia_inverse_iteration_point.sv]
// Throughput: one point per cycle unless the output queue is full; each cell is
// 133 stages (two 32-stage square roots, a 64-stage divider and five arithmetic
// stages), all advancing together.
// A two-entry output queue keeps taking points while one result waits; the chain
// stalls only when both entries are full.
// Reset clears all valid flags and sets c_re, c_im and digit_order to zero.
module julia_inverse_iteration_point import jii_pkg::*; #(
   parameter int DIGITS    = 30,
   parameter int FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [29:0] digit_word, [31:30] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] z_re, [63:32] z_im
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] c_re_ff, c_im_ff;
   logic        order_ff;
   logic        cfg_wr;
   logic        en;
   point_type   chain [0:DIGITS];
   logic        push, pop;
   logic        head_v_in, head_v_ff, skid_v_in, skid_v_ff;
   logic [63:0] head_in, head_ff, skid_in, skid_ff;
   logic [63:0] last_data;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_re_ff  <= 32'd0;
         c_im_ff  <= 32'd0;
         order_ff <= 1'b0;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_C_RE:  c_re_ff  <= csr_pwdata;
            REG_C_IM:  c_im_ff  <= csr_pwdata;
            REG_ORDER: order_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_C_RE:  csr_prdata = c_re_ff;
         REG_C_IM:  csr_prdata = c_im_ff;
         REG_ORDER: csr_prdata = {31'd0, order_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // The whole chain advances unless the output queue is full.
   assign en         = !skid_v_ff;
   assign req_tready = en;

   assign chain[0].valid = req_tvalid && en;
   assign chain[0].word  = req_tdata[WORD_BITS-1:0];
   assign chain[0].re    = 32'sd0;
   assign chain[0].im    = 32'sd0;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      jii_cell #(
         .FRAC_BITS (FRAC_BITS),
         .POS_LSB   (i),
         .POS_MSB   (DIGITS - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .c_re    (c_re_ff),
         .c_im    (c_im_ff),
         .order   (order_ff),
         .pt_prev (chain[i]),
         .pt      (chain[i+1])
      );
   end

   // Two-entry output queue: head drives the port, skid catches one more point.
   assign last_data = {chain[DIGITS].im, chain[DIGITS].re};
   assign push      = en && chain[DIGITS].valid;
   assign pop       = head_v_ff && rsp_tready;

   always_comb begin
      head_v_in = head_v_ff;
      head_in   = head_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!head_v_ff) begin
         head_v_in = push;
         head_in   = last_data;
      end else if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            skid_v_in = push;
            skid_in   = last_data;
         end else begin
            head_v_in = push;
            head_in   = last_data;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = last_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = head_v_ff;
   assign rsp_tdata  = head_ff;

endmodule

[hw/rtl/jii_checker.sv]
// Port-level checks for the Julia-set point pipeline, bound to the top level.
module jii_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // A stalled result keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The input side only stalls while a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // A register write that lands on c_re reads back the written value.
   a_cfg_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr == 4'h0 ##1
      csr_paddr == 4'h0 && $stable(csr_paddr) |-> csr_prdata == $past(csr_pwdata))
      else $error("c_re readback mismatch");

   // Ready is tied high on the register port.
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind julia_inverse_iteration_point jii_checker u_jii_checker (.*);

[verif/julia_inverse_iteration_point_tb.sv]
// Self-checking testbench for the Julia-set point pipeline with stream and APB-style ports.
module julia_inverse_iteration_point_tb;
   import jii_pkg::*;

   localparam int DIGITS    = 30;
   localparam int FRAC_BITS = 28;
   localparam int LATENCY   = DIGITS * 133 + 1;
   localparam int CYCLE_LIMIT = 2000000;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [29:0] digit_word, [31:30] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [31:0] z_re, [63:32] z_im
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the configuration registers.
   longint      shadow_c_re;
   longint      shadow_c_im;
   bit          shadow_msb_first;

   logic [63:0] expected_points[$];
   int          mismatches;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          cycle_count;

   julia_inverse_iteration_point #(.DIGITS(DIGITS), .FRAC_BITS(FRAC_BITS)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Principal square root of a + ib with truncation and saturation.
   function automatic void principal_root(input longint a, input longint b,
                                          output longint re, output longint im);
      longint unsigned ua, ub, m, p, q;
      longint sp, sq;
      ua = (a < 0) ? longint'(-a) : longint'(a);
      ub = (b < 0) ? longint'(-b) : longint'(b);
      if (a == 0 && b == 0) begin
         re = 0;
         im = 0;
      end else begin
         m = int_sqrt(ua * ua + ub * ub);
         p = int_sqrt((m + ua) << (FRAC_BITS - 1));
         q = (p != 0) ? (ub << (FRAC_BITS - 1)) / p : 0;
         sp = (p > 64'd2147483647) ? S32_MAX : longint'(p);
         sq = (q > 64'd2147483647) ? S32_MAX : longint'(q);
         if (a >= 0) begin
            re = sp;
            im = (b < 0) ? -sq : sq;
         end else begin
            re = sq;
            im = (b < 0) ? -sp : sp;
         end
      end
   endfunction

   // Walks the digits from z = 0 and returns {z_im, z_re}.
   function automatic logic [63:0] julia_point(input logic [WORD_BITS-1:0] word);
      longint zr, zi, nr, ni;
      int pos;
      bit negate;
      zr = 0;
      zi = 0;
      for (int i = 0; i < DIGITS; i++) begin
         pos = shadow_msb_first ? (DIGITS - 1 - i) : i;
         negate = (pos < WORD_BITS) && word[pos];
         principal_root(clamp32(zr - shadow_c_re), clamp32(zi - shadow_c_im), nr, ni);
         zr = negate ? clamp32(-nr) : nr;
         zi = negate ? clamp32(-ni) : ni;
      end
      return {zi[31:0], zr[31:0]};
   endfunction

   // Result checking against the oldest expected point.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", rsp_tdata);
         end else begin
            logic [63:0] exp_point;
            exp_point = expected_points.pop_front();
            if (rsp_tdata[31:0] !== exp_point[31:0] || rsp_tdata[63:32] !== exp_point[63:32]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: z_re exp %h got %h, z_im exp %h got %h",
                           exp_point[31:0], rsp_tdata[31:0],
                           exp_point[63:32], rsp_tdata[63:32]);
            end
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (index)
         REG_C_RE:  shadow_c_re = longint'(signed'(value));
         REG_C_IM:  shadow_c_im = longint'(signed'(value));
         REG_ORDER: shadow_msb_first = value[0];
         default: ;
      endcase
   endtask

   task automatic set_parameters(input logic [31:0] c_re, input logic [31:0] c_im,
                                 input bit msb_first);
      write_register(REG_C_RE, c_re);
      write_register(REG_C_IM, c_im);
      write_register(REG_ORDER, {31'd0, msb_first});
   endtask

   // Sends one digit word; called and returning at a falling edge.
   task automatic send_word(input logic [WORD_BITS-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, word};
      do @(posedge clock); while (!req_tready);
      expected_points.push_back(julia_point(word));
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid = 1'b0;
      while (expected_points.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] random_c;
      if ($urandom_range(9) == 0) return $urandom;
      return $urandom_range(32'h4000_0000) - 32'h2000_0000;
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word;
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return WORD_BITS'($urandom);
      endcase
   endfunction

   // Extreme words, single digits and extreme values of c in both orders.
   task automatic test_directed;
      set_parameters(32'd0, 32'd0, 1'b0);
      send_word('0);
      send_word('1);
      drain;
      set_parameters(32'hE000_0000, 32'h0400_0000, 1'b0);
      send_word('0);
      send_word('1);
      send_word(30'h2AAA_AAAA);
      send_word(30'h1555_5555);
      send_word(30'h0000_0001);
      send_word(30'h2000_0000);
      drain;
      set_parameters(32'hE000_0000, 32'h0400_0000, 1'b1);
      send_word(30'h0000_0001);
      send_word(30'h2000_0000);
      send_word(30'h2AAA_AAAA);
      drain;
      // Differences that saturate.
      set_parameters(32'h8000_0000, 32'h8000_0000, 1'b1);
      send_word('0);
      send_word('1);
      send_word(30'h1555_5555);
      drain;
      set_parameters(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_word('0);
      send_word('1);
      send_word(30'h2AAA_AAAA);
      drain;
      set_parameters(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_word('0);
      send_word('1);
      drain;
   endtask

   task automatic test_random(input int send_pct, input int recv_pct, input bit hold_off);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int phase = 0; phase < 3; phase++) begin
         set_parameters(random_c(), random_c(), 1'($urandom_range(1)));
         for (int n = 0; n < 200; n++) begin
            if (hold_off && phase == 1 && n == 100) drain;
            send_word(random_word());
         end
         drain;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      shadow_c_re = 0;
      shadow_c_im = 0;
      shadow_msb_first = 1'b0;
      mismatches = 0;
      cycle_count = 0;
      send_idle_pct = 15;
      recv_idle_pct = 72;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(15, 72, 1'b1);
      test_random(72, 15, 1'b0);
      test_random(0, 0, 1'b0);

      repeat (LATENCY / 100) @(negedge clock);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
